[rtl/lpfd_pkg.sv]
// Shared types, codes and reset values for the length-prefixed frame deframer.
package lpfd_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned CNT_W     = 3;

	// Deframer phase codes
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_HALT    = 2'd2;

	// Error kinds
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MAGIC  = 2'd1;
	localparam logic [1:0] ERR_CODE   = 2'd2;
	localparam logic [1:0] ERR_LENGTH = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_EXPECTED_MAGIC = 2'd0;
	localparam logic [1:0] CFG_MAX_CODE       = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH     = 2'd2;

	localparam logic [15:0] MAGIC_RESET      = 16'h4878;
	localparam logic [15:0] MAX_CODE_RESET   = 16'd100;
	localparam logic [31:0] MAX_LENGTH_RESET = 32'd10000000;

	typedef struct packed {
		logic [15:0] expected_magic;
		logic [15:0] max_code;
		logic [31:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        byte_present;
		logic [15:0] frame_code;
		logic        frame_last;
		logic [1:0]  error_kind;
	} result_t;

endpackage

[rtl/lpfd_cfg.sv]
// Configuration register file of the deframer.
module lpfd_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output lpfd_pkg::cfg_t      cfg
);
	import lpfd_pkg::*;

	logic [15:0] magic_q;
	logic [15:0] max_code_q;
	logic [31:0] max_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q      <= MAGIC_RESET;
			max_code_q   <= MAX_CODE_RESET;
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_MAGIC: magic_q      <= cfg_data[15:0];
				CFG_MAX_CODE:       max_code_q   <= cfg_data[15:0];
				CFG_MAX_LENGTH:     max_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.expected_magic = magic_q;
	assign cfg.max_code       = max_code_q;
	assign cfg.max_length     = max_length_q;

endmodule

[rtl/lpfd_parse.sv]
// Input register, header collection, header checks and payload tracking.
module lpfd_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  lpfd_pkg::cfg_t      cfg,
	input  logic                res_take,
	output logic                res_valid,
	output lpfd_pkg::result_t   res
);
	import lpfd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic [1:0]       phase_q, phase_d;
	logic [55:0]      shift_q, shift_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      rem_q, rem_d;
	logic [15:0]      code_q, code_d;

	logic [63:0] full;
	logic [15:0] hdr_magic;
	logic [15:0] hdr_code;
	logic [31:0] hdr_len;
	logic [1:0]  hdr_err;
	logic [31:0] rem_dec;

	assign advance  = valid_s1 && res_take;
	assign in_stall = valid_s1 && !res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign full      = {shift_q, byte_s1};
	assign hdr_magic = full[63:48];
	assign hdr_code  = full[47:32];
	assign hdr_len   = full[31:0];
	assign rem_dec   = (rem_q == 32'd0) ? 32'd0 : rem_q - 32'd1;

	// Checks in priority order: magic, code, length
	always_comb begin
		if (hdr_magic != cfg.expected_magic) begin
			hdr_err = ERR_MAGIC;
		end else if (hdr_code > cfg.max_code) begin
			hdr_err = ERR_CODE;
		end else if (hdr_len > cfg.max_length) begin
			hdr_err = ERR_LENGTH;
		end else begin
			hdr_err = ERR_NONE;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		shift_d   = shift_q;
		count_d   = count_q;
		rem_d     = rem_q;
		code_d    = code_q;
		res_valid = 1'b0;
		res       = '0;
		if (advance) begin
			case (phase_q)
				PH_HEADER: begin
					if (count_q != CNT_W'(HDR_BYTES - 1)) begin
						shift_d = {shift_q[47:0], byte_s1};
						count_d = count_q + CNT_W'(1);
					end else begin
						shift_d = '0;
						count_d = '0;
						if (hdr_err != ERR_NONE) begin
							phase_d        = PH_HALT;
							res_valid      = 1'b1;
							res.error_kind = hdr_err;
						end else begin
							code_d = hdr_code;
							if (hdr_len == 32'd0) begin
								// empty frame: one last result, no data
								res_valid      = 1'b1;
								res.frame_code = hdr_code;
								res.frame_last = 1'b1;
							end else begin
								rem_d   = hdr_len;
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					rem_d            = rem_dec;
					res_valid        = 1'b1;
					res.payload_byte = byte_s1;
					res.byte_present = 1'b1;
					res.frame_code   = code_q;
					res.frame_last   = (rem_dec == 32'd0);
					if (rem_dec == 32'd0) begin
						phase_d = PH_HEADER;
					end
				end
				default: ; // halted: drop the item
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			shift_q <= '0;
			count_q <= '0;
			rem_q   <= '0;
			code_q  <= '0;
		end else begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			code_q  <= code_d;
		end
	end

endmodule

[rtl/lpfd_out.sv]
// Result register feeding the output channel.
module lpfd_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  lpfd_pkg::result_t   res,
	output logic                res_take,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          payload_byte,
	output logic                byte_present,
	output logic [15:0]         frame_code,
	output logic                frame_last,
	output logic [1:0]          error_kind
);
	import lpfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	// slot frees when empty or when the held item leaves this cycle
	assign res_take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign payload_byte = res_q.payload_byte;
	assign byte_present = res_q.byte_present;
	assign frame_code   = res_q.frame_code;
	assign frame_last   = res_q.frame_last;
	assign error_kind   = res_q.error_kind;

endmodule

[rtl/length_prefixed_frame_deframer_core.sv]
// Length-prefixed frame deframer: top level.
// An accepted byte goes to the input register; its result is then held in the result register.
// Throughput: one byte per cycle while out_stall is low; the header and payload logic closes
// in one pass per byte.
// Bytes after an error and header bytes but the last of a bad or zero-length one give no result.
// Reset (arst_n low, asynchronous) empties both registers, restarts header collection,
// clears the halt and loads the default magic and limits.
module length_prefixed_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        byte_present,
	output logic [15:0] frame_code,
	output logic        frame_last,
	output logic [1:0]  error_kind,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import lpfd_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    res_valid;
	logic    res_take;

	lpfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (res)
	);

	lpfd_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_present (byte_present),
		.frame_code   (frame_code),
		.frame_last   (frame_last),
		.error_kind   (error_kind)
	);

endmodule
